@@ hdl/dee_pkg.sv @@
// Shared constants, types and helper functions of the delimited event extractor.
package dee_pkg;

    localparam int MAX_EVENT_BYTES   = 64;
    localparam int MAX_PATTERN_BYTES = 8;

    localparam int BYTE_W    = 8;
    localparam int PAT_W     = BYTE_W * MAX_PATTERN_BYTES;
    localparam int LEN_W     = 4;
    localparam int PTR_W     = $clog2(MAX_EVENT_BYTES);
    localparam int CNT_W     = $clog2(MAX_EVENT_BYTES + 1);
    localparam int WIN_IDX_W = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = PAT_W;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_HEAD_PATTERN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAD_LEN     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TAIL_PATTERN = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TAIL_LEN     = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;    // write the incoming byte into the queue
        logic decide;    // evaluate head/tail match and latch the drain plan
        logic rd_issue;  // read the oldest queued byte from the buffer
        logic emit;      // move the read byte into the output register
    } dee_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic drain_any;   // the plan being decided has at least one byte to send
        logic drain_last;  // the byte being emitted is the last of the plan
        logic out_free;    // the output register can take a new item this cycle
    } dee_status_t;

    // Clamp a configured pattern length into 1..MAX_PATTERN_BYTES.
    function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] len);
        logic [LEN_W-1:0] res;
        if (len == '0)
            res = LEN_W'(1);
        else if (len > LEN_W'(MAX_PATTERN_BYTES))
            res = LEN_W'(MAX_PATTERN_BYTES);
        else
            res = len;
        return res;
    endfunction

endpackage

@@ hdl/dee_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module dee_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hdl/dee_datapath.sv @@
// Datapath: configuration registers, byte queue, match window and output register.
module dee_datapath (
    input  logic                            clk,
    input  logic                            rst_n,
    input  dee_pkg::dee_cmd_t               cmd,
    output dee_pkg::dee_status_t            status,
    input  logic                            cfg_we,
    input  logic [dee_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [dee_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic [dee_pkg::BYTE_W-1:0]      data_byte,
    input  logic                            out_stall,
    output logic                            out_valid,
    output logic [dee_pkg::BYTE_W-1:0]      out_byte,
    output logic                            is_event,
    output logic                            event_last
);
    import dee_pkg::*;

    logic [PAT_W-1:0]  head_pattern_reg;
    logic [LEN_W-1:0]  head_len_reg;
    logic [PAT_W-1:0]  tail_pattern_reg;
    logic [LEN_W-1:0]  tail_len_reg;

    logic [CNT_W-1:0]  count_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic              in_event_reg;
    logic [CNT_W-1:0]  drain_left_reg;
    logic              ev_mode_reg;

    logic              out_valid_reg;
    logic [BYTE_W-1:0] out_byte_reg;
    logic              is_event_reg;
    logic              event_last_reg;

    // Newest received bytes; entry 0 is the most recent.
    logic [BYTE_W-1:0] win_reg [MAX_PATTERN_BYTES];

    logic [LEN_W-1:0]  hl;
    logic [LEN_W-1:0]  tl;
    logic              head_hit;
    logic              tail_hit;
    logic [CNT_W-1:0]  plan_n;
    logic              plan_ev;
    logic              plan_in_event;
    logic [PTR_W-1:0]  wr_addr;
    logic [BYTE_W-1:0] ram_rd_data;

    // True when the newest n bytes equal the first n bytes of the pattern.
    function automatic logic ends_with(input logic [PAT_W-1:0] pattern,
                                       input logic [LEN_W-1:0] n,
                                       input logic [CNT_W-1:0] cnt,
                                       input logic [BYTE_W-1:0] win [MAX_PATTERN_BYTES]);
        logic             hit;
        logic [LEN_W-1:0] back;
        hit = (CNT_W'(n) <= cnt);
        for (int i = 0; i < MAX_PATTERN_BYTES; i++)
        begin
            back = n - LEN_W'(1) - LEN_W'(i);
            if (LEN_W'(i) < n && win[back[WIN_IDX_W-1:0]] != pattern[BYTE_W*i +: BYTE_W])
                hit = 1'b0;
        end
        return hit;
    endfunction

    assign hl = eff_len(head_len_reg);
    assign tl = eff_len(tail_len_reg);

    assign head_hit = ends_with(head_pattern_reg, hl, count_reg, win_reg);
    assign tail_hit = (count_reg >= CNT_W'(hl) + CNT_W'(tl))
                      && ends_with(tail_pattern_reg, tl, count_reg, win_reg);

    // Drain plan for the byte just queued.
    always_comb
    begin
        plan_n        = '0;
        plan_ev       = 1'b0;
        plan_in_event = in_event_reg;
        if (!in_event_reg)
        begin
            if (head_hit)
            begin
                // Bytes older than the head go out plain.
                plan_n        = count_reg - CNT_W'(hl);
                plan_in_event = 1'b1;
            end
            else if (count_reg >= CNT_W'(hl))
            begin
                plan_n = count_reg - CNT_W'(hl) + CNT_W'(1);
            end
        end
        else if (tail_hit)
        begin
            plan_n        = count_reg;
            plan_ev       = 1'b1;
            plan_in_event = 1'b0;
        end
        else if (count_reg >= CNT_W'(MAX_EVENT_BYTES))
        begin
            // Buffer full without a tail: release everything as plain bytes.
            plan_n        = count_reg;
            plan_in_event = 1'b0;
        end
    end

    assign wr_addr = rd_ptr_reg + count_reg[PTR_W-1:0];

    dee_ram #(
        .WIDTH(BYTE_W),
        .DEPTH(MAX_EVENT_BYTES)
    ) u_queue (
        .clk    (clk),
        .wr_en  (cmd.accept),
        .wr_addr(wr_addr),
        .wr_data(data_byte),
        .rd_en  (cmd.rd_issue),
        .rd_addr(rd_ptr_reg),
        .rd_data(ram_rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_pattern_reg <= '0;
            head_len_reg     <= LEN_W'(1);
            tail_pattern_reg <= '0;
            tail_len_reg     <= LEN_W'(1);
            count_reg        <= '0;
            rd_ptr_reg       <= '0;
            in_event_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_HEAD_PATTERN: head_pattern_reg <= cfg_data;
                    CFG_HEAD_LEN:     head_len_reg     <= cfg_data[LEN_W-1:0];
                    CFG_TAIL_PATTERN: tail_pattern_reg <= cfg_data;
                    CFG_TAIL_LEN:     tail_len_reg     <= cfg_data[LEN_W-1:0];
                    default:          ;
                endcase
            end

            if (cmd.accept)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (cmd.decide)
            begin
                count_reg    <= count_reg - plan_n;
                in_event_reg <= plan_in_event;
            end

            if (cmd.emit)
            begin
                rd_ptr_reg    <= rd_ptr_reg + PTR_W'(1);
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            win_reg[0] <= data_byte;
            for (int k = 1; k < MAX_PATTERN_BYTES; k++)
            begin
                win_reg[k] <= win_reg[k-1];
            end
        end
        if (cmd.decide)
        begin
            drain_left_reg <= plan_n;
            ev_mode_reg    <= plan_ev;
        end
        else if (cmd.emit)
        begin
            drain_left_reg <= drain_left_reg - CNT_W'(1);
        end
        if (cmd.emit)
        begin
            out_byte_reg   <= ram_rd_data;
            is_event_reg   <= ev_mode_reg;
            event_last_reg <= ev_mode_reg && (drain_left_reg == CNT_W'(1));
        end
    end

    assign status.drain_any  = (plan_n != '0);
    assign status.drain_last = (drain_left_reg == CNT_W'(1));
    assign status.out_free   = !out_valid_reg || !out_stall;

    assign out_valid  = out_valid_reg;
    assign out_byte   = out_byte_reg;
    assign is_event   = is_event_reg;
    assign event_last = event_last_reg;

endmodule

@@ hdl/dee_ctrl.sv @@
// Controller: sequences accept, decision and byte-by-byte drain of the queue.
module dee_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  dee_pkg::dee_status_t  status,
    output dee_pkg::dee_cmd_t     cmd
);
    import dee_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_READ,
        ST_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        in_stall     = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall   = 1'b0;
                cmd.accept = in_valid;
                if (in_valid)
                    state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                cmd.decide = 1'b1;
                state_next = status.drain_any ? ST_READ : ST_IDLE;
            end
            ST_READ:
            begin
                cmd.rd_issue = 1'b1;
                state_next   = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = status.drain_last ? ST_IDLE : ST_READ;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ hdl/delimited_event_extractor.sv @@
// Top level of the delimited event extractor: controller plus datapath.
//
//   Channel   Signals                                  Direction
//   input     in_valid, in_stall, data_byte            one received byte per item
//   output    out_valid, out_stall, out_byte,          one emitted byte per item
//             is_event, event_last
//   config    cfg_we, cfg_index, cfg_data              register write, no read-back
//
// An item is taken while the controller is idle, and the next cycle decides how many
// queued bytes leave. Each released byte takes a queue RAM read and then an output
// register load, and the load waits on out_stall; an item that releases nothing
// returns the controller to idle right after the decision.
// Reset clears the queue count, the event flag, the output valid and the registers
// to their defaults; the queue RAM itself is not cleared and needs no clearing pass.
// in_stall is high whenever the controller is not idle; the output register lets a
// new item be accepted while the last result still waits on out_stall.
module delimited_event_extractor (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [dee_pkg::BYTE_W-1:0]      data_byte,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [dee_pkg::BYTE_W-1:0]      out_byte,
    output logic                            is_event,
    output logic                            event_last,
    input  logic                            cfg_we,
    input  logic [dee_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [dee_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import dee_pkg::*;

    dee_cmd_t    cmd;
    dee_status_t status;

    // The controller owns the handshake on the input side and paces the drain.
    dee_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .status  (status),
        .cmd     (cmd)
    );

    // The datapath keeps the queue, the match window of recent bytes, the
    // hunting/event flag and the output register.
    dee_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .data_byte (data_byte),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_byte  (out_byte),
        .is_event  (is_event),
        .event_last(event_last)
    );

endmodule

@@ tb/sv/dee_extract_checker.sv @@
// Checker for the delimited event extractor: predicts every emitted byte and compares it.
module dee_extract_checker
    import dee_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_stall,
    input  logic [BYTE_W-1:0]     data_byte,
    input  logic                  out_valid,
    input  logic                  out_stall,
    input  logic [BYTE_W-1:0]     out_byte,
    input  logic                  is_event,
    input  logic                  event_last,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    errors,
    output int                    due_left,
    output int                    bytes_checked,
    output int                    events_closed
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [BYTE_W-1:0] value;
        logic              ev;
        logic              last;
    } due_byte_t;

    // Bytes the block owes on its output, oldest first.
    due_byte_t due_bytes[$];

    // Shadow copy of the registers and of the byte queue inside the block.
    logic [PAT_W-1:0]  head_pat;
    logic [PAT_W-1:0]  tail_pat;
    logic [LEN_W-1:0]  head_len_raw;
    logic [LEN_W-1:0]  tail_len_raw;
    logic [BYTE_W-1:0] held [MAX_EVENT_BYTES];
    int unsigned       held_n;
    bit                in_frame;

    // A length of zero acts as one, anything above the pattern size acts as the size.
    function automatic int unsigned clamp_len(input logic [LEN_W-1:0] raw);
        if (raw == '0)
            return 1;
        if (raw > LEN_W'(MAX_PATTERN_BYTES))
            return MAX_PATTERN_BYTES;
        return 32'(raw);
    endfunction

    // True when the newest n held bytes spell the first n bytes of the pattern.
    function automatic bit newest_match(input logic [PAT_W-1:0] pat, input int unsigned n);
        int unsigned i;
        if (n > held_n)
            return 0;
        for (i = 0; i < n; i++)
        begin
            if (held[held_n - n + i] != pat[8*i +: 8])
                return 0;
        end
        return 1;
    endfunction

    task automatic release_plain(input int unsigned n);
        int unsigned i;
        for (i = 0; i < n; i++)
            due_bytes.push_back('{value: held[i], ev: 1'b0, last: 1'b0});
        for (i = 0; i + n < held_n; i++)
            held[i] = held[i + n];
        held_n -= n;
    endtask

    task automatic absorb_byte(input logic [BYTE_W-1:0] b);
        int unsigned hl;
        int unsigned tl;
        int unsigned i;
        hl = clamp_len(head_len_raw);
        tl = clamp_len(tail_len_raw);
        if (held_n >= MAX_EVENT_BYTES)
        begin
            held_n = 0;
            in_frame = 0;
        end
        held[held_n] = b;
        held_n++;
        if (!in_frame)
        begin
            if (newest_match(head_pat, hl))
            begin
                release_plain(held_n - hl);
                in_frame = 1;
            end
            else if (held_n >= hl)
                release_plain(held_n - hl + 1);
        end
        else if (held_n >= hl + tl && newest_match(tail_pat, tl))
        begin
            for (i = 0; i < held_n; i++)
                due_bytes.push_back('{value: held[i], ev: 1'b1, last: (i + 1 == held_n)});
            held_n = 0;
            in_frame = 0;
        end
        else if (held_n >= MAX_EVENT_BYTES)
        begin
            release_plain(held_n);
            in_frame = 0;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        due_byte_t want;
        if (!rst_n)
        begin
            head_pat = '0;
            tail_pat = '0;
            head_len_raw = LEN_W'(1);
            tail_len_raw = LEN_W'(1);
            held_n = 0;
            in_frame = 0;
            due_bytes.delete();
            errors = 0;
            bytes_checked = 0;
            events_closed = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (due_bytes.size() == 0)
                begin
                    $error("out_byte: nothing expected, got %02h", out_byte);
                    errors++;
                end
                else
                begin
                    want = due_bytes.pop_front();
                    bytes_checked++;
                    if (want.last)
                        events_closed++;
                    if (out_byte !== want.value)
                    begin
                        $error("out_byte: expected %02h, got %02h", want.value, out_byte);
                        errors++;
                    end
                    if (is_event !== want.ev)
                    begin
                        $error("is_event: expected %0b, got %0b", want.ev, is_event);
                        errors++;
                    end
                    if (event_last !== want.last)
                    begin
                        $error("event_last: expected %0b, got %0b", want.last, event_last);
                        errors++;
                    end
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_HEAD_PATTERN: head_pat = cfg_data;
                    CFG_HEAD_LEN:     head_len_raw = cfg_data[LEN_W-1:0];
                    CFG_TAIL_PATTERN: tail_pat = cfg_data;
                    CFG_TAIL_LEN:     tail_len_raw = cfg_data[LEN_W-1:0];
                    default:          ;
                endcase
            end
            if (in_valid && !in_stall)
                absorb_byte(data_byte);
        end
        due_left = due_bytes.size();
    end

endmodule

@@ tb/sv/tb_top.sv @@
// Top of the delimited event extractor testbench: clock, reset, stimulus and verdict.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import dee_pkg::*;

    localparam int STALL_PCT      = 17;    // chance in percent that a side idles in a cycle
    localparam int HOLD_CYCLES    = 300;   // long receiver hold-off that backs up the block
    localparam int PHASE_ITEMS    = 28;    // input items per random register setting
    localparam int RANDOM_PHASES  = 5;
    localparam int DRAIN_CYCLES   = 12;    // lets an item that releases nothing finish
    localparam int WATCHDOG_LIMIT = 4000;  // cycles with no accepted item before giving up

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [BYTE_W-1:0]     data_byte = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [BYTE_W-1:0]     out_byte;
    logic                  is_event;
    logic                  event_last;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_HEAD_PATTERN;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    int errors;
    int due_left;
    int bytes_checked;
    int events_closed;

    // Stimulus bookkeeping.
    bit          calm = 1'b0;      // when set, neither side idles
    bit          hold_req = 1'b0;  // asks the receiver for one long hold-off
    int unsigned items_sent = 0;
    int unsigned settings_used = 0;
    int unsigned quiet_cycles = 0;

    // The register values now in force, as the stimulus needs them to build frames.
    logic [PAT_W-1:0] cur_hp;
    logic [PAT_W-1:0] cur_tp;
    int unsigned      cur_hl;
    int unsigned      cur_tl;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    delimited_event_extractor dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .data_byte  (data_byte),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_byte   (out_byte),
        .is_event   (is_event),
        .event_last (event_last),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    // The checker watches both channels and the register port and keeps the expected bytes.
    dee_extract_checker extract_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .data_byte     (data_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_byte      (out_byte),
        .is_event      (is_event),
        .event_last    (event_last),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .errors        (errors),
        .due_left      (due_left),
        .bytes_checked (bytes_checked),
        .events_closed (events_closed)
    );

    // Receiver. It stalls at random, not at all during a calm phase, and once holds off for
    // a long stretch so that the output register and then the input side back up.
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_stall = 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            out_stall = !calm && ($urandom_range(0, 99) < STALL_PCT);
        end
    end

    // Watchdog. Any accepted item on either channel restarts the count; a run that goes
    // quiet for too long has hung and is failed.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Offers one byte, possibly after a few idle cycles, and returns at the falling edge
    // after it was taken. Valid stays high into the next call, so back-to-back bytes see no
    // gap unless the next call decides to idle.
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        while (!calm && $urandom_range(0, 99) < STALL_PCT)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        data_byte = b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
        items_sent++;
    endtask

    // Waits until every expected byte has come out, then lets the block finish any item
    // that released nothing before registers may be touched again.
    task automatic settle();
        in_valid = 1'b0;
        while (due_left != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        @(negedge clk);
    endtask

    // Writes all four registers in consecutive cycles. Lengths go out raw, so zero and
    // values above eight reach the block; the stimulus keeps the lengths they act as.
    task automatic load_patterns(input logic [PAT_W-1:0] hp, input logic [LEN_W-1:0] hl,
                                 input logic [PAT_W-1:0] tp, input logic [LEN_W-1:0] tl);
        put_reg(CFG_HEAD_PATTERN, hp);
        put_reg(CFG_HEAD_LEN, CFG_DATA_W'(hl));
        put_reg(CFG_TAIL_PATTERN, tp);
        put_reg(CFG_TAIL_LEN, CFG_DATA_W'(tl));
        cfg_we = 1'b0;
        cur_hp = hp;
        cur_tp = tp;
        cur_hl = (hl == '0) ? 1
                 : ((hl > LEN_W'(MAX_PATTERN_BYTES)) ? MAX_PATTERN_BYTES : 32'(hl));
        cur_tl = (tl == '0) ? 1
                 : ((tl > LEN_W'(MAX_PATTERN_BYTES)) ? MAX_PATTERN_BYTES : 32'(tl));
        settings_used++;
    endtask

    // One random frame. Most frames are a real head, a random body and a real tail. Some
    // are noise, some leave the tail out so the next frame lands inside an open event,
    // and a few carry a full buffer of body bytes with no tail at all.
    task automatic send_frame();
        int unsigned kind;
        int unsigned body;
        int unsigned i;
        kind = $urandom_range(0, 19);
        if (kind < 4)
        begin
            body = $urandom_range(1, 6);
            for (i = 0; i < body; i++)
                send_byte(BYTE_W'($urandom_range(0, 255)));
        end
        else
        begin
            for (i = 0; i < cur_hl; i++)
                send_byte(cur_hp[8*i +: 8]);
            body = (kind == 19) ? MAX_EVENT_BYTES : $urandom_range(0, 12);
            for (i = 0; i < body; i++)
                send_byte(BYTE_W'($urandom_range(0, 255)));
            if (kind >= 7 && kind != 19)
            begin
                for (i = 0; i < cur_tl; i++)
                    send_byte(cur_tp[8*i +: 8]);
            end
        end
    endtask

    initial
    begin
        int unsigned i;
        int unsigned ph;
        int unsigned phase_start;

        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Head length zero acts as one, tail length fifteen acts as eight. Two plain bytes
        // at the data extremes pass straight through, then a one-byte head and an
        // eight-byte tail make a nine-byte event.
        load_patterns(64'h7E, 4'd0, 64'h0807060504030201, 4'd15);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h7E);
        for (i = 1; i <= 8; i++)
            send_byte(BYTE_W'(i));
        settle();

        // Head and tail are the same single byte. The byte that opens the event must not
        // also close it; only the next one does.
        load_patterns(64'hFF, 4'd1, 64'hFF, 4'd1);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'hFF);
        settle();

        // With an eight-byte head, seven unmatched bytes stay held back and nothing comes out.
        load_patterns(64'h8877665544332211, 4'd8, 64'h0, 4'd1);
        send_byte(8'h10);
        send_byte(8'h20);
        send_byte(8'h30);
        send_byte(8'h40);
        send_byte(8'h50);
        send_byte(8'h60);
        send_byte(8'h3C);
        settle();

        // The head shrinks to two bytes while the queue still holds those seven. The next
        // byte completes the new head, so the six older bytes leave plain in the same step;
        // then a zero tail closes a three-byte event.
        load_patterns(64'hC33C, 4'd2, 64'h0, 4'd1);
        send_byte(8'hC3);
        send_byte(8'h00);
        settle();

        // Random settings, each followed by random frames. The second setting starts with
        // the long receiver hold-off, the third runs with no idling on either side.
        for (ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            load_patterns({$urandom, $urandom}, LEN_W'($urandom_range(0, 10)),
                          {$urandom, $urandom}, LEN_W'($urandom_range(0, 10)));
            calm = (ph == 2);
            if (ph == 1)
                hold_req = 1'b1;
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS)
                send_frame();
            settle();
            calm = 1'b0;
        end

        $display("tb: %0d input bytes under %0d register settings, including a held-back",
                 items_sent, settings_used);
        $display("tb: queue and a long output hold-off; %0d output bytes checked, %0d events",
                 bytes_checked, events_closed);
        if (errors == 0 && due_left == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
